FILE: design/assert_macros.svh
// Assertion macros shared by the font loader RTL.
// Depends on nothing; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check of one property, sampled on the rising clock edge.
`define PSF1_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
// Concurrent check that a trigger is followed by its consequence in the next cycle.
`define PSF1_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("%m: next-cycle property failed");
`else
`define PSF1_ASSERT(label, clk, rst_n, prop)
`define PSF1_ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif
`endif

FILE: design/psf1_pkg.sv
// Shared constants, codes and types of the PSF1 font loader and glyph fetch.
// Depends on nothing; psf1_ctrl and the top level import it.
package psf1_pkg;

  // Sizing of the glyph store.
  localparam int MAX_GLYPHS  = 512;
  localparam int MAX_ROWS    = 32;
  localparam int STORE_DEPTH = MAX_GLYPHS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CP_W        = $clog2(MAX_GLYPHS);
  localparam int KEPT_W      = $clog2(MAX_GLYPHS) + 1;

  // Fixed widths of the file format and the result fields.
  localparam int ROWS_W = 6;
  localparam int CNT_W  = 15;
  localparam int NEED_W = 16;
  localparam int KR_W   = KEPT_W + ROWS_W;

  localparam logic [CNT_W-1:0]  CNT_MAX         = {CNT_W{1'b1}};
  localparam logic [7:0]        MAGIC0          = 8'h36;
  localparam logic [7:0]        MAGIC1          = 8'h04;
  localparam logic [7:0]        QMARK           = 8'h3F;
  localparam logic [ROWS_W-1:0] FALLBACK_HEIGHT = 6'd8;
  localparam logic [NEED_W-1:0] HEADER_BYTES    = 16'd4;
  localparam logic [NEED_W-1:0] GLYPHS_WIDE     = 16'd512;
  localparam logic [NEED_W-1:0] GLYPHS_NARROW   = 16'd256;

  // Request operation.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Result kind.
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_ROW  = 1'b1
  } kind_t;

  // Load status; ST_OK also marks "no header error seen".
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_MAGIC  = 2'd2,
    ST_HEIGHT = 2'd3
  } status_t;

  // Registered result side information; row data comes from the store.
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    status_t           status;
    logic              zero_row;
    logic [ROWS_W-1:0] height;
    logic              fallback;
  } res_t;

  // Number of glyphs that are kept and addressable for a font.
  function automatic logic [KEPT_W-1:0] kept_glyphs(logic wide);
    int n;
    n = wide ? 512 : 256;
    if (n > MAX_GLYPHS) n = MAX_GLYPHS;
    return KEPT_W'(n);
  endfunction

endpackage

FILE: design/psf1_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; contents are undefined until written.
module psf1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/psf1_ctrl.sv
// Header parser, load state and row address logic of the font loader.
// Depends on psf1_pkg and assert_macros.svh; drives the glyph store ports.
`include "assert_macros.svh"
module psf1_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  psf1_pkg::op_t            in_op,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_last_byte,
  input  logic [15:0]              in_codepoint,
  input  logic [4:0]               in_row_index,
  output logic                     ram_we,
  output logic [psf1_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]               ram_wdata,
  output logic                     ram_re,
  output logic [psf1_pkg::ADDR_W-1:0] ram_raddr,
  output psf1_pkg::res_t           res_r
);
  import psf1_pkg::*;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  status_t           herr_r, herr_nxt, herr_b;
  logic              wide_r, wide_nxt, wide_b;
  logic [ROWS_W-1:0] rows_r, rows_nxt, rows_b;
  logic              valid_r, valid_nxt, valid_b;
  logic              clr;
  logic [CNT_W-1:0]  widx;
  logic [KR_W-1:0]   kept_rows;
  logic [NEED_W-1:0] need, total;
  status_t           status;
  logic [CP_W-1:0]   cp_eff;
  logic [KR_W-1:0]   ridx;
  res_t              res_nxt;

  // Per-request next state, store access and result side information.
  always_comb begin
    clr       = (cnt_r == '0);
    herr_b    = clr ? ST_OK : herr_r;
    wide_b    = clr ? 1'b0 : wide_r;
    rows_b    = clr ? '0 : rows_r;
    valid_b   = clr ? 1'b0 : valid_r;
    cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
    widx      = cnt_r - CNT_W'(4);
    kept_rows = KR_W'(kept_glyphs(wide_b)) * KR_W'(rows_b);

    herr_nxt  = herr_r;
    wide_nxt  = wide_r;
    rows_nxt  = rows_r;
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    need      = '0;
    total     = '0;
    status    = ST_OK;
    ram_we    = 1'b0;
    ram_waddr = widx[ADDR_W-1:0];
    ram_wdata = {<<{in_data_byte}};
    ram_re    = 1'b0;
    cp_eff    = '0;
    ridx      = '0;

    res_nxt          = '0;
    res_nxt.valid    = 1'b0;
    res_nxt.kind     = KIND_LOAD;
    res_nxt.status   = ST_OK;
    res_nxt.zero_row = 1'b1;
    res_nxt.height   = FALLBACK_HEIGHT;
    res_nxt.fallback = 1'b1;

    if (accept && in_op == OP_LOAD) begin
      herr_nxt  = herr_b;
      wide_nxt  = wide_b;
      rows_nxt  = rows_b;
      valid_nxt = valid_b;
      cnt_nxt   = cnt_inc;

      // Header fields first, then glyph bytes while the header is clean.
      priority if (cnt_r == CNT_W'(0) && in_data_byte != MAGIC0 && herr_b == ST_OK) begin
        herr_nxt = ST_MAGIC;
      end else if (cnt_r == CNT_W'(1) && in_data_byte != MAGIC1 && herr_b == ST_OK) begin
        herr_nxt = ST_MAGIC;
      end else if (cnt_r == CNT_W'(2)) begin
        wide_nxt = in_data_byte[0];
      end else if (cnt_r == CNT_W'(3)) begin
        if (in_data_byte == 8'd0 || in_data_byte > 8'(MAX_ROWS)) begin
          if (herr_b == ST_OK) herr_nxt = ST_HEIGHT;
          rows_nxt = '0;
        end else begin
          rows_nxt = in_data_byte[ROWS_W-1:0];
        end
      end else if (cnt_r >= CNT_W'(4) && herr_b == ST_OK) begin
        ram_we = ({1'b0, widx} < KR_W'(kept_rows));
      end else begin
        herr_nxt = herr_b;
      end

      // End of file: grade the load and report it.
      if (in_last_byte) begin
        total = NEED_W'(cnt_inc);
        need  = HEADER_BYTES + (wide_nxt ? GLYPHS_WIDE : GLYPHS_NARROW) * NEED_W'(rows_nxt);
        priority if (total < HEADER_BYTES) begin
          status = ST_SHORT;
        end else if (herr_nxt != ST_OK) begin
          status = herr_nxt;
        end else if (total < need) begin
          status = ST_SHORT;
        end else begin
          status = ST_OK;
        end
        valid_nxt        = (status == ST_OK);
        cnt_nxt          = '0;
        res_nxt.valid    = 1'b1;
        res_nxt.status   = status;
        res_nxt.height   = (status == ST_OK) ? rows_nxt : FALLBACK_HEIGHT;
        res_nxt.fallback = (status != ST_OK);
      end
    end else if (accept) begin
      // Row read: out-of-range codepoints use the question mark glyph.
      cp_eff = (KEPT_W'(in_codepoint) >= kept_glyphs(wide_r) || |in_codepoint[15:KEPT_W])
               ? CP_W'(QMARK) : in_codepoint[CP_W-1:0];
      ridx   = KR_W'(cp_eff) * KR_W'(rows_r) + KR_W'(in_row_index);
      ram_re = valid_r && (ROWS_W'(in_row_index) < rows_r);
      res_nxt.valid    = 1'b1;
      res_nxt.kind     = KIND_ROW;
      res_nxt.zero_row = !ram_re;
      res_nxt.height   = valid_r ? rows_r : FALLBACK_HEIGHT;
      res_nxt.fallback = !valid_r;
    end
    ram_raddr = ridx[ADDR_W-1:0];
  end

  // Load state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      herr_r  <= ST_OK;
      wide_r  <= 1'b0;
      rows_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      herr_r  <= herr_nxt;
      wide_r  <= wide_nxt;
      rows_r  <= rows_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result register: only the strobe is reset, the side information stays
  // aligned with the store read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= res_nxt.valid;
    end
    res_r.kind     <= res_nxt.kind;
    res_r.status   <= res_nxt.status;
    res_r.zero_row <= res_nxt.zero_row;
    res_r.height   <= res_nxt.height;
    res_r.fallback <= res_nxt.fallback;
  end

  `PSF1_ASSERT_NEXT(a_mid_load_silent, clk, rst_n, accept && in_op == OP_LOAD && !in_last_byte, !res_r.valid)
  `PSF1_ASSERT_NEXT(a_request_answered, clk, rst_n, accept && (in_op == OP_READ || in_last_byte), res_r.valid)
  `PSF1_ASSERT_NEXT(a_load_end_restarts, clk, rst_n, accept && in_op == OP_LOAD && in_last_byte, cnt_r == '0)
  `PSF1_ASSERT(a_write_without_font, clk, rst_n, ram_we |-> !valid_r)
  `PSF1_ASSERT(a_read_needs_font, clk, rst_n, ram_re |-> valid_r && rows_r != '0)

endmodule

FILE: design/psf1_font_loader_glyph_fetch.sv
// Top level of the PSF1 font loader and glyph row fetch.
// Depends on psf1_pkg, psf1_ctrl and psf1_ram.
//
// A new request is accepted in every cycle, so busy stays low. Each request
// that has a result (a row read, or the load byte marked last) produces it on
// out_valid in the cycle after acceptance, in step with the registered read
// port of the 16384 x 8 glyph store. The result is present for a single cycle
// only and the receiver cannot stall it. The glyph store needs no clearing
// after reset: rows are only read from a font that loaded successfully, and
// reads without one report fallback with height 8.
module psf1_font_loader_glyph_fetch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [15:0] in_codepoint,
  input  logic [4:0]  in_row_index,
  output logic        out_valid,
  output logic        out_result_kind,
  output logic [1:0]  out_load_status,
  output logic [7:0]  out_row_bits,
  output logic [5:0]  out_font_height,
  output logic        out_use_fallback
);
  import psf1_pkg::*;

  logic              accept;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  res_t              res;

  // Requests are taken in every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  psf1_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_op        (op_t'(in_op)),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_codepoint (in_codepoint),
    .in_row_index (in_row_index),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .res_r        (res)
  );

  psf1_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_glyph_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result ports: row data from the store unless the row reads as blank.
  assign out_valid        = res.valid;
  assign out_result_kind  = res.kind;
  assign out_load_status  = res.status;
  assign out_row_bits     = res.zero_row ? 8'h00 : ram_rdata;
  assign out_font_height  = res.height;
  assign out_use_fallback = res.fallback;

endmodule

FILE: tb/tb_psf1_font_loader_glyph_fetch.sv
// Self-checking testbench for the PSF1 font loader and glyph row fetch.
// Depends on psf1_pkg and psf1_font_loader_glyph_fetch; a built-in font model
// predicts every load status and glyph row the block returns.
`timescale 1ns / 1ps

module tb_psf1_font_loader_glyph_fetch;
  import psf1_pkg::*;

  // Requests sent over the whole run.
  localparam int ITEM_COUNT = 1150;

  // Expected contents of one result strobe.
  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [7:0]  bits;
    logic [5:0]  height;
    logic        fallback;
  } glyph_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_op;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic [15:0] in_codepoint;
  logic [4:0]  in_row_index;
  logic        out_valid;
  logic        out_result_kind;
  logic [1:0]  out_load_status;
  logic [7:0]  out_row_bits;
  logic [5:0]  out_font_height;
  logic        out_use_fallback;

  // Font model state.
  logic [7:0]  glyph_mem [0:STORE_DEPTH-1];
  logic [14:0] byte_pos;
  status_t     hdr_fault;
  logic        wide_font;
  int          glyph_rows;
  logic        font_ok;

  glyph_result_t results_due[$];
  int            mismatch_count;
  int            sent_count;
  logic          steady_flow;
  logic          reads_during_load;

  psf1_font_loader_glyph_fetch dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .in_codepoint     (in_codepoint),
    .in_row_index     (in_row_index),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_load_status  (out_load_status),
    .out_row_bits     (out_row_bits),
    .out_font_height  (out_font_height),
    .out_use_fallback (out_use_fallback)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

  // Glyph rows are stored bit-reversed, with the leftmost pixel moved to the LSB.
  function automatic logic [7:0] mirror_pixels(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = b[7-i];
    return r;
  endfunction

  // Glyphs that the store keeps for the current font.
  function automatic int usable_glyphs();
    int n;
    n = wide_font ? 512 : 256;
    return (n > MAX_GLYPHS) ? MAX_GLYPHS : n;
  endfunction

  // Bytes a complete font file of the given shape holds.
  function automatic int file_bytes(input logic wide, input int rows);
    return int'(HEADER_BYTES) + (wide ? 512 : 256) * rows;
  endfunction

  // Advances the font model by one accepted request and queues its result.
  task automatic predict_font_access(input op_t op, input logic [7:0] data,
                                     input logic last, input logic [15:0] cp,
                                     input logic [4:0] row);
    glyph_result_t res;
    status_t       st;
    int            pos;
    int            idx;
    int            glyph;
    res = '0;
    pos = int'(byte_pos);
    if (op == OP_LOAD) begin
      // The first byte of a file drops whatever font was loaded.
      if (pos == 0) begin
        font_ok    = 1'b0;
        hdr_fault  = ST_OK;
        wide_font  = 1'b0;
        glyph_rows = 0;
      end
      if (pos == 0 && data != MAGIC0 && hdr_fault == ST_OK) begin
        hdr_fault = ST_MAGIC;
      end else if (pos == 1 && data != MAGIC1 && hdr_fault == ST_OK) begin
        hdr_fault = ST_MAGIC;
      end else if (pos == 2) begin
        wide_font = data[0];
      end else if (pos == 3) begin
        if (data == 8'd0 || int'(data) > MAX_ROWS) begin
          if (hdr_fault == ST_OK) hdr_fault = ST_HEIGHT;
          glyph_rows = 0;
        end else begin
          glyph_rows = int'(data);
        end
      end else if (pos >= 4 && hdr_fault == ST_OK) begin
        idx = pos - 4;
        if (idx < usable_glyphs() * glyph_rows && idx < STORE_DEPTH)
          glyph_mem[idx] = mirror_pixels(data);
      end
      if (byte_pos < CNT_MAX) byte_pos = byte_pos + 15'd1;
      if (!last) return;
      // Status at the end of the file, short header first.
      if (int'(byte_pos) < int'(HEADER_BYTES)) st = ST_SHORT;
      else if (hdr_fault != ST_OK) st = hdr_fault;
      else if (int'(byte_pos) < file_bytes(wide_font, glyph_rows)) st = ST_SHORT;
      else st = ST_OK;
      font_ok      = (st == ST_OK);
      byte_pos     = '0;
      res.kind     = KIND_LOAD;
      res.status   = st;
      res.bits     = 8'd0;
      res.height   = font_ok ? 6'(glyph_rows) : FALLBACK_HEIGHT;
      res.fallback = !font_ok;
    end else begin
      res.kind   = KIND_ROW;
      res.status = ST_OK;
      if (!font_ok) begin
        res.bits     = 8'd0;
        res.height   = FALLBACK_HEIGHT;
        res.fallback = 1'b1;
      end else begin
        // Codepoints past the font show the question mark glyph.
        glyph = int'(cp);
        if (glyph >= usable_glyphs()) glyph = int'(QMARK);
        res.bits     = (int'(row) < glyph_rows) ?
                       glyph_mem[glyph * glyph_rows + int'(row)] : 8'd0;
        res.height   = 6'(glyph_rows);
        res.fallback = 1'b0;
      end
    end
    results_due.push_back(res);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Drives one request, after a random pause unless the flow is steady, and waits until it is taken.
  task automatic send_request(input op_t op, input logic [7:0] data, input logic last,
                              input logic [15:0] cp, input logic [4:0] row);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_data_byte <= data;
    in_last_byte <= last;
    in_codepoint <= cp;
    in_row_index <= row;
    do @(posedge clk); while (busy !== 1'b0);
    predict_font_access(op, data, last, cp, row);
    sent_count++;
  endtask

  task automatic read_row(input logic [15:0] cp, input logic [4:0] row);
    send_request(OP_READ, 8'($urandom), 1'($urandom), cp, row);
  endtask

  // Streams a font file: up to four header bytes, then random glyph bytes, with occasional row reads when enabled.
  task automatic load_font(input logic [7:0] m0, input logic [7:0] m1,
                           input logic [7:0] mode, input logic [7:0] height,
                           input int total);
    logic [7:0] b;
    for (int pos = 0; pos < total; pos++) begin
      case (pos)
        0:       b = m0;
        1:       b = m1;
        2:       b = mode;
        3:       b = height;
        default: b = 8'($urandom);
      endcase
      send_request(OP_LOAD, b, pos == total - 1, 16'($urandom), 5'($urandom));
      if (reads_during_load && pos != total - 1 && $urandom_range(0, 63) == 0)
        read_row(16'($urandom), 5'($urandom));
    end
  endtask

  // Compares every result strobe with the oldest prediction.
  always @(posedge clk) begin : check_results
    glyph_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = results_due.pop_front();
        if (out_result_kind !== want.kind)
          report_mismatch($sformatf("result_kind %0d, expected %0d",
                                    out_result_kind, want.kind));
        if (out_load_status !== want.status)
          report_mismatch($sformatf("load_status %0d, expected %0d",
                                    out_load_status, want.status));
        if (out_row_bits !== want.bits)
          report_mismatch($sformatf("row_bits %02h, expected %02h",
                                    out_row_bits, want.bits));
        if (out_font_height !== want.height)
          report_mismatch($sformatf("font_height %0d, expected %0d",
                                    out_font_height, want.height));
        if (out_use_fallback !== want.fallback)
          report_mismatch($sformatf("use_fallback %0d, expected %0d",
                                    out_use_fallback, want.fallback));
      end
    end else if (rst_n && out_valid !== 1'b0) begin
      report_mismatch("out_valid is unknown");
    end
  end

  // Reads with nothing loaded only flag the fallback font.
  task automatic test_fallback_reads();
    read_row(16'h0000, 5'd0);
    read_row(16'hFFFF, 5'd31);
    read_row(16'h003F, 5'd7);
  endtask

  // Every header failure, and the priority among them.
  task automatic test_header_checks();
    load_font(MAGIC0, MAGIC1, 8'h00, 8'd8, 1);
    load_font(MAGIC0, MAGIC1, 8'h00, 8'd8, 3);
    load_font(8'h00, MAGIC1, 8'h00, 8'd1, 2);
    load_font(8'h00, MAGIC1, 8'h00, 8'd8, 5);
    load_font(MAGIC0, 8'hFF, 8'h00, 8'd8, 5);
    load_font(8'hFF, 8'h00, 8'h00, 8'd0, 4);
    load_font(MAGIC0, MAGIC1, 8'h00, 8'd0, 5);
    load_font(MAGIC0, MAGIC1, 8'h01, 8'(MAX_ROWS + 1), 4);
    load_font(MAGIC0, MAGIC1, 8'h00, 8'hFF, 4);
    load_font(MAGIC0, MAGIC1, 8'h00, 8'd1, 4);
    read_row(16'h0041, 5'd0);
  endtask

  // Narrow font: one byte short, then complete with extra bytes, then row reads.
  task automatic test_narrow_font();
    load_font(MAGIC0, MAGIC1, 8'hFE, 8'd1, file_bytes(1'b0, 1) - 1);
    load_font(MAGIC0, MAGIC1, 8'hFE, 8'd1, file_bytes(1'b0, 1) + 2);
    read_row(16'd0, 5'd0);
    read_row(16'd0, 5'd1);
    read_row(16'd255, 5'd0);
    read_row(16'd256, 5'd0);
    read_row(16'hFFFF, 5'd1);
    read_row(16'd65, 5'd0);
    read_row(16'd65, 5'd31);
    // A new file drops the font at its first byte.
    send_request(OP_LOAD, MAGIC0, 1'b1, 16'd0, 5'd0);
    read_row(16'd65, 5'd0);
  endtask

  // Wide font with every glyph present, with reads mixed into the load.
  task automatic test_wide_font();
    reads_during_load = 1'b1;
    load_font(MAGIC0, MAGIC1, 8'h01, 8'd1, file_bytes(1'b1, 1));
    reads_during_load = 1'b0;
    read_row(16'd0, 5'd0);
    read_row(16'd511, 5'd0);
    read_row(16'd511, 5'd31);
    read_row(16'd512, 5'd0);
    read_row(16'hFFFF, 5'd0);
    read_row(16'h8000, 5'd0);
    repeat (8) read_row(16'($urandom_range(0, 511)), 5'($urandom_range(0, 1)));
  endtask

  // Row reads and broken files, plus complete small fonts while the request
  // budget still has room for them.
  task automatic test_random_traffic();
    int         left;
    int         pick;
    int         h;
    logic       wide;
    logic [7:0] m0;
    logic [7:0] m1;
    reads_during_load = 1'b1;
    while (sent_count < ITEM_COUNT) begin
      left        = ITEM_COUNT - sent_count;
      steady_flow = ($urandom_range(0, 4) == 0);
      pick        = $urandom_range(0, 99);
      wide        = 1'($urandom);
      m0          = MAGIC0;
      m1          = MAGIC1;
      if (pick >= 45 && pick < 55 && left < file_bytes(1'b1, 1) + 4) pick = 60;
      if (pick < 45) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0, 1:    read_row(16'($urandom_range(0, 255)), 5'($urandom));
            2:       read_row(16'($urandom_range(256, 511)), 5'($urandom_range(0, 3)));
            default: read_row(16'($urandom), 5'($urandom));
          endcase
        end
      end else if (pick < 52) begin
        // Complete narrow font, sometimes with trailing bytes.
        h = $urandom_range(1, 2);
        load_font(MAGIC0, MAGIC1, {7'($urandom), 1'b0}, 8'(h),
                  file_bytes(1'b0, h) + (($urandom_range(0, 3) == 0) ? 3 : 0));
      end else if (pick < 55) begin
        load_font(MAGIC0, MAGIC1, {7'($urandom), 1'b1}, 8'd1,
                  file_bytes(1'b1, 1) + $urandom_range(0, 1));
      end else if (pick < 66) begin
        // Valid header but the glyph data stops early.
        load_font(MAGIC0, MAGIC1, {7'($urandom), wide}, 8'($urandom_range(1, MAX_ROWS)),
                  int'(HEADER_BYTES) + $urandom_range(0, 40));
      end else if (pick < 75) begin
        load_font(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  $urandom_range(1, 3));
      end else if (pick < 88) begin
        if ($urandom_range(0, 1) == 1) begin
          m0 = 8'($urandom);
          if (m0 == MAGIC0) m0 = m0 ^ 8'h80;
        end else begin
          m1 = 8'($urandom);
          if (m1 == MAGIC1) m1 = m1 ^ 8'h01;
        end
        load_font(m0, m1, 8'($urandom), 8'($urandom), $urandom_range(1, 20));
      end else begin
        load_font(MAGIC0, MAGIC1, 8'($urandom),
                  ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(MAX_ROWS + 1, 255)),
                  $urandom_range(4, 20));
      end
    end
    steady_flow = 1'b0;
  endtask

  // Lets the last results drain, then gives the verdict.
  task automatic finish_run();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (results_due.size() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  endtask

  // Reset, then the tests in turn.
  initial begin
    byte_pos          = '0;
    hdr_fault         = ST_OK;
    wide_font         = 1'b0;
    glyph_rows        = 0;
    font_ok           = 1'b0;
    mismatch_count    = 0;
    sent_count        = 0;
    steady_flow       = 1'b0;
    reads_during_load = 1'b0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_op        <= OP_LOAD;
    in_data_byte <= 8'd0;
    in_last_byte <= 1'b0;
    in_codepoint <= 16'd0;
    in_row_index <= 5'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_fallback_reads();
    test_header_checks();
    test_narrow_font();
    test_wide_font();
    test_random_traffic();
    finish_run();
  end

endmodule
